>>> rtl/rps_pkg.sv
`default_nettype none

package rps_pkg;

   // Field widths of the channels.
   localparam int WORD_W       = 16;
   localparam int COUNT_W      = 5;
   localparam int SLOT_INDEX_W = 4;
   localparam int SLOT_VALUE_W = 5;

   // Element count after reset.
   localparam int COUNT_RESET = 9;

   // Sequencer state codes.
   typedef logic [2:0] state_type;
   localparam state_type ST_IDLE   = 3'd0;
   localparam state_type ST_DIV    = 3'd1;
   localparam state_type ST_READ   = 3'd2;
   localparam state_type ST_SWAP_A = 3'd3;
   localparam state_type ST_SWAP_B = 3'd4;

endpackage

`default_nettype wire

>>> rtl/random_permutation_shuffler_unit.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_random_word
// rsp       out        rsp_valid / rsp_stall  rsp_slot_index, rsp_slot_value, rsp_final_slot
// csr       in         csr_valid / csr_ready  csr_element_count
//
// Each item passes through the restoring divider, which retires one quotient bit per cycle,
// then one table read and two writes on the single write port of the table memory,
// before the next item is accepted.
// Reset restores the identity table at once through per-entry valid bits.
// A stalled result waits in the output register while the next item is accepted;
// the block only holds in its last write cycle when a new result finds that register full.

module random_permutation_shuffler_unit
   import rps_pkg::*;
#(
   parameter int MAX_ELEMENTS = 16,
   parameter int RANDOM_BITS  = 16
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire  [WORD_W-1:0]        req_random_word,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [SLOT_INDEX_W-1:0]  rsp_slot_index,
   output logic [SLOT_VALUE_W-1:0]  rsp_slot_value,
   output logic                     rsp_final_slot,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire  [COUNT_W-1:0]       csr_element_count
);

   localparam int IDX_W     = $clog2(MAX_ELEMENTS);
   localparam int CNT_W     = $clog2(MAX_ELEMENTS + 1);
   localparam int WORD_BITS = (RANDOM_BITS < WORD_W) ? RANDOM_BITS : WORD_W;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int CNT_RESET = (COUNT_RESET > MAX_ELEMENTS) ? MAX_ELEMENTS : COUNT_RESET;

   // Control registers.
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         cursor_ff, cursor_in;
   logic [MAX_ELEMENTS-1:0]  valid_ff, valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [CNT_W-1:0]         div_d_ff, div_d_in;
   logic [WORD_BITS-1:0]     word_ff, word_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [BIT_W-1:0]         bit_cnt_ff, bit_cnt_in;
   logic [IDX_W-1:0]         partner_ff;
   logic [CNT_W-1:0]         rd_a_ff, rd_b_ff;
   logic                     va_ff, vb_ff;
   logic [SLOT_INDEX_W-1:0]  slot_index_ff;
   logic [SLOT_VALUE_W-1:0]  slot_value_ff;
   logic                     final_slot_ff;

   // Permutation table memory.
   logic [CNT_W-1:0]         table_mem [MAX_ELEMENTS];

   logic [CNT_W:0]           trial;
   logic                     trial_ge;
   logic [CNT_W:0]           partner_sum;
   logic [IDX_W-1:0]         partner_c;
   logic [CNT_W-1:0]         val_a;
   logic [CNT_W-1:0]         val_b;
   logic                     last_pos;
   logic                     out_free;
   logic                     load_rsp;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic [CNT_W-1:0]         mem_wdata;
   logic [CNT_W-1:0]         csr_clamped;

   // One restoring division step on the remainder.
   assign trial    = {rem_ff, word_ff[WORD_BITS-1]};
   assign trial_ge = (trial >= {1'b0, div_d_ff});

   // Swap partner is the cursor plus the remainder.
   assign partner_sum = (CNT_W+1)'(cursor_ff) + (CNT_W+1)'(rem_ff);
   assign partner_c   = IDX_W'(partner_sum);

   // Entries never written since the last restart read as the identity.
   assign val_a = va_ff ? rd_a_ff : CNT_W'(cursor_ff) + CNT_W'(1);
   assign val_b = vb_ff ? rd_b_ff : CNT_W'(partner_ff) + CNT_W'(1);

   assign last_pos = (CNT_W'(cursor_ff) == count_ff - CNT_W'(1));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp = (state_ff == ST_SWAP_B) && out_free;

   // Clamp a written count into 1 to MAX_ELEMENTS.
   always_comb begin
      if (csr_element_count == '0) begin
         csr_clamped = CNT_W'(1);
      end else if (32'(csr_element_count) > MAX_ELEMENTS) begin
         csr_clamped = CNT_W'(MAX_ELEMENTS);
      end else begin
         csr_clamped = CNT_W'(csr_element_count);
      end
   end

   // Sequencer and next-state logic.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      valid_in     = valid_ff;
      div_d_in     = div_d_ff;
      word_in      = word_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      mem_we       = 1'b0;
      mem_waddr    = cursor_ff;
      mem_wdata    = val_b;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               count_in  = csr_clamped;
               cursor_in = '0;
               valid_in  = '0;
            end else if (req_valid) begin
               div_d_in   = count_ff - CNT_W'(cursor_ff);
               word_in    = req_random_word[WORD_BITS-1:0];
               rem_in     = '0;
               bit_cnt_in = BIT_W'(WORD_BITS - 1);
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = trial_ge ? CNT_W'(trial - {1'b0, div_d_ff}) : trial[CNT_W-1:0];
            word_in = word_ff << 1;
            bit_cnt_in = bit_cnt_ff - BIT_W'(1);
            if (bit_cnt_ff == '0) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SWAP_A;
         end
         ST_SWAP_A: begin
            mem_we              = 1'b1;
            mem_waddr           = cursor_ff;
            mem_wdata           = val_b;
            valid_in[cursor_ff] = 1'b1;
            state_in            = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            if (out_free) begin
               mem_we       = 1'b1;
               mem_waddr    = partner_ff;
               mem_wdata    = val_a;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (last_pos) begin
                  valid_in  = '0;
                  cursor_in = '0;
               end else begin
                  valid_in[partner_ff] = 1'b1;
                  cursor_in            = cursor_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_W'(CNT_RESET);
         cursor_ff    <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Divider and result payload.
   always_ff @(posedge clock) begin
      div_d_ff   <= div_d_in;
      word_ff    <= word_in;
      rem_ff     <= rem_in;
      bit_cnt_ff <= bit_cnt_in;
      if (state_ff == ST_READ) begin
         partner_ff <= partner_c;
         va_ff      <= valid_ff[cursor_ff];
         vb_ff      <= valid_ff[partner_c];
      end
      if (load_rsp) begin
         slot_index_ff <= SLOT_INDEX_W'(cursor_ff);
         slot_value_ff <= SLOT_VALUE_W'(val_b);
         final_slot_ff <= last_pos;
      end
   end

   // Table memory: two registered reads, one write per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         rd_a_ff <= table_mem[cursor_ff];
         rd_b_ff <= table_mem[partner_c];
      end
   end

   assign req_stall      = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = slot_index_ff;
   assign rsp_slot_value = slot_value_ff;
   assign rsp_final_slot = final_slot_ff;

endmodule

`default_nettype wire

>>> rtl/rps_checker.sv
`default_nettype none

module rps_checker
   import rps_pkg::*;
(
   input wire                     clock,
   input wire                     reset,
   input wire                     req_valid,
   input wire                     req_stall,
   input wire                     rsp_valid,
   input wire                     rsp_stall,
   input wire [SLOT_INDEX_W-1:0]  rsp_slot_index,
   input wire [SLOT_VALUE_W-1:0]  rsp_slot_value,
   input wire                     rsp_final_slot
);

   // No result is shown right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result keeps its valid and its fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot_index)
         && $stable(rsp_slot_value) && $stable(rsp_final_slot))
      else $error("stalled result changed");

   // An accepted item occupies the block, so the next cycle stalls the input.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while another is in work");

   // An item passes through the divider before its result is loaded, so no result appears the cycle after acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result too early after item");

   // Permuted values start at one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_slot_value != '0)
      else $error("result value of zero");

endmodule

bind random_permutation_shuffler_unit rps_checker u_rps_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps

// One emitted slot of the permutation, as the block reports it.
typedef struct {
   logic [rps_pkg::SLOT_INDEX_W-1:0] index;
   logic [rps_pkg::SLOT_VALUE_W-1:0] value;
   logic                             last_flag;
} slot_result_type;

// Shadow of the shuffle state and the queue of slots still to be emitted.
class shuffle_scoreboard;
   logic [rps_pkg::SLOT_VALUE_W-1:0] slots [16];
   int unsigned                      cursor;
   int unsigned                      count;
   slot_result_type                  expected_slots [$];
   int                               errors;
   int                               checked;
   int                               words_noted;

   function new();
      count = rps_pkg::COUNT_RESET;
      errors = 0;
      checked = 0;
      words_noted = 0;
      restart();
   endfunction

   // Identity table and cursor back at the first position.
   function void restart();
      for (int k = 0; k < 16; k++) begin
         slots[k] = rps_pkg::SLOT_VALUE_W'(k + 1);
      end
      cursor = 0;
   endfunction

   // A count write saturates into 1..16 and restarts the shuffle.
   function void set_count(logic [rps_pkg::COUNT_W-1:0] v);
      if (v == 0) begin
         count = 1;
      end else if (v > 16) begin
         count = 16;
      end else begin
         count = 32'(v);
      end
      restart();
   endfunction

   // One accepted random word: swap with the chosen partner and emit the slot.
   function void note_word(logic [rps_pkg::WORD_W-1:0] word);
      int unsigned                      pos;
      int unsigned                      partner;
      logic [rps_pkg::SLOT_VALUE_W-1:0] held;
      slot_result_type                  slot;
      pos = cursor;
      if (pos >= count) begin
         pos = 0;
      end
      partner = pos + (32'(word) % (count - pos));
      if (partner > 15) begin
         partner = 15;
      end
      held = slots[pos];
      slots[pos] = slots[partner];
      slots[partner] = held;
      slot.index = pos[3:0];
      slot.value = slots[pos];
      slot.last_flag = (pos == count - 1);
      expected_slots.push_back(slot);
      words_noted++;
      if (slot.last_flag) begin
         restart();
      end else begin
         cursor = pos + 1;
      end
   endfunction

   // Compare one accepted slot with the oldest prediction.
   function void check_result(logic [rps_pkg::SLOT_INDEX_W-1:0] index,
                              logic [rps_pkg::SLOT_VALUE_W-1:0] value,
                              logic last_flag);
      slot_result_type exp_slot;
      if (expected_slots.size() == 0) begin
         $display("%0t: unexpected slot index %0d value %0d last %0d",
                  $time, index, value, last_flag);
         errors++;
         return;
      end
      exp_slot = expected_slots.pop_front();
      checked++;
      if (index !== exp_slot.index) begin
         $display("%0t: slot_index expected %0d actual %0d", $time, exp_slot.index, index);
         errors++;
      end
      if (value !== exp_slot.value) begin
         $display("%0t: slot_value expected %0d actual %0d", $time, exp_slot.value, value);
         errors++;
      end
      if (last_flag !== exp_slot.last_flag) begin
         $display("%0t: final_slot expected %0d actual %0d",
                  $time, exp_slot.last_flag, last_flag);
         errors++;
      end
   endfunction

   function int pending();
      return expected_slots.size();
   endfunction
endclass

module tb_top;
   import rps_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 400;
   localparam int LONG_HOLD    = 300;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [WORD_W-1:0]       req_random_word;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [SLOT_INDEX_W-1:0] rsp_slot_index;
   logic [SLOT_VALUE_W-1:0] rsp_slot_value;
   logic                    rsp_final_slot;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [COUNT_W-1:0]      csr_element_count;

   shuffle_scoreboard sb;
   int                send_idle_pct;
   int                rsp_idle_pct;
   int                hold_requests;
   int                hold_served = 0;
   int                hold_left = 0;
   int                cycle_count = 0;
   int                count_writes;

   random_permutation_shuffler_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_random_word   (req_random_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_slot_value    (rsp_slot_value),
      .rsp_final_slot    (rsp_final_slot),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_element_count (csr_element_count)
   );

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** random_permutation_shuffler_unit: FAILED **");
         $finish;
      end
   end

   // Monitor both channels on the clock edge where each item is accepted.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_word(req_random_word);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_slot_index, rsp_slot_value, rsp_final_slot);
         end
      end
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // Offer one random word, with random idle cycles ahead of it.
   task automatic send_word(input logic [WORD_W-1:0] word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_random_word <= WORD_W'($urandom_range(0, 65535));
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_random_word <= word;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   // Stop offering and wait until every predicted slot has come out.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write the element count while the block is idle.
   task automatic write_count(input logic [COUNT_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_element_count <= v;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      sb.set_count(v);
      count_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return WORD_W'($urandom_range(0, 31));
         default: return WORD_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0: return 5'd0;
         1: return 5'd1;
         2: return 5'd16;
         3: return COUNT_W'($urandom_range(17, 31));
         4: return 5'd2;
         default: return COUNT_W'($urandom_range(2, 16));
      endcase
   endfunction

   initial begin
      int phase_items;
      int burst;
      sb = new();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_requests = 0;
      count_writes = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_random_word = '0;
      csr_valid = 1'b0;
      csr_element_count = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: one full shuffle at the reset count, with extreme words.
      send_word(16'h0000);
      send_word(16'hFFFF);
      send_word(16'h0001);
      send_word(16'h8000);
      send_word(16'h5555);
      send_word(16'hAAAA);
      send_word(16'h7FFF);
      send_word(16'h0008);
      send_word(16'h1234);

      // Directed: count written as zero saturates to one element.
      write_count(5'd0);
      send_word(16'hFFFF);
      send_word(16'h0000);

      // Directed: all count bits set saturates to the maximum.
      write_count(5'd31);
      for (int k = 0; k < 5; k++) begin
         send_word((k % 2) ? 16'hFFFF : 16'h0000);
      end

      // Directed: a count of one, then a partial shuffle cut by a count write.
      write_count(5'd1);
      send_word(16'hABCD);
      write_count(5'd16);
      send_word(16'hFFFF);
      send_word(16'h000F);

      // Random phases with different idling on each side.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 20;
               rsp_idle_pct = 72;
            end
            1: begin
               send_idle_pct = 72;
               rsp_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            write_count(pick_count());
            burst = $urandom_range(1, 3 * sb.count + 3);
            // In the last phase, hold the result side off while words keep coming.
            if (phase == 2 && phase_items == 0) begin
               hold_requests++;
               burst = 40;
            end
            for (int k = 0; k < burst; k++) begin
               send_word(pick_word());
            end
            phase_items += burst;
         end
      end

      // Let the pipeline empty and watch for stray results.
      drain();
      repeat (40) @(posedge clock);

      $display("Shuffled %0d random words over %0d element-count writes,", sb.words_noted,
               count_writes);
      $display("checked %0d emitted slots with %0d mismatches.", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** random_permutation_shuffler_unit: PASSED **");
      end else begin
         $display("** random_permutation_shuffler_unit: FAILED **");
      end
      $finish;
   end

endmodule
